### hw/rtl/bdq_pkg.sv
package bdq_pkg;

  // Queue geometry.
  localparam int DEPTH = 16;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // Action codes.
  localparam logic [1:0] ACT_PUSH_BACK  = 2'd0;
  localparam logic [1:0] ACT_PUSH_FRONT = 2'd1;
  localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
  localparam logic [1:0] ACT_POP_BACK   = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Request word.
  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] push_value;
  } req_word_t;

  // Result word.
  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic [4:0]         fill_level;
  } res_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic execute;
  } bdq_cmd_t;

endpackage

### hw/rtl/bdq_ctrl.sv
module bdq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output bdq_pkg::bdq_cmd_t cmd
);
  import bdq_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    REPLY
  } state_t;

  state_t state;

  // A request is taken in IDLE; the memory access runs in EXEC.
  assign cmd.load    = (state == IDLE) && start;
  assign cmd.execute = (state == EXEC);

  // Sequencer with registered busy and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= EXEC;
            busy  <= 1'b1;
          end
        end
        EXEC: begin
          state <= REPLY;
          done  <= 1'b1;
        end
        REPLY: begin
          state <= IDLE;
          done  <= 1'b0;
          busy  <= 1'b0;
        end
        default: begin
          state <= IDLE;
          done  <= 1'b0;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

### hw/rtl/bdq_datapath.sv
module bdq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  bdq_pkg::bdq_cmd_t  cmd,
  input  bdq_pkg::req_word_t request,
  output bdq_pkg::res_word_t result
);
  import bdq_pkg::*;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);

  logic signed [31:0] store [DEPTH];

  req_word_t          req;
  logic [PTR_W-1:0]   head;
  logic [CNT_W-1:0]   count;
  logic signed [31:0] rdata;
  logic               pop_ok;
  logic [1:0]         status;

  logic               full;
  logic               empty;
  logic [SUM_W-1:0]   back_sum;
  logic [PTR_W-1:0]   back_slot;
  logic [PTR_W-1:0]   head_dec;
  logic [PTR_W-1:0]   head_inc;
  logic [PTR_W-1:0]   addr;
  logic               wr_en;
  logic               rd_en;
  logic [PTR_W-1:0]   head_next;
  logic [CNT_W-1:0]   count_next;
  logic [1:0]         status_next;

  assign full  = (count == DEPTH_C);
  assign empty = (count == '0);

  // Slot past the back on a push, or of the back word on a pop, wrapped once.
  always_comb begin
    if (req.action == ACT_POP_BACK) begin
      back_sum = SUM_W'(head) + SUM_W'(count) - SUM_W'(1);
    end else begin
      back_sum = SUM_W'(head) + SUM_W'(count);
    end
    if (back_sum >= DEPTH_S) begin
      back_slot = PTR_W'(back_sum - DEPTH_S);
    end else begin
      back_slot = PTR_W'(back_sum);
    end
  end

  assign head_dec = (head == '0) ? LAST_SLOT : head - PTR_W'(1);
  assign head_inc = (head == LAST_SLOT) ? '0 : head + PTR_W'(1);

  // Decode the action into at most one memory access and the pointer update.
  always_comb begin
    addr        = head;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    head_next   = head;
    count_next  = count;
    status_next = ST_DONE;
    case (req.action)
      ACT_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          addr       = back_slot;
          wr_en      = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          addr       = head_dec;
          wr_en      = 1'b1;
          head_next  = head_dec;
          count_next = count + CNT_W'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          addr       = head;
          rd_en      = 1'b1;
          head_next  = head_inc;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          addr       = back_slot;
          rd_en      = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
    endcase
  end

  // Word store with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.execute && wr_en) begin
      store[addr] <= req.push_value;
    end
    if (cmd.execute && rd_en) begin
      rdata <= store[addr];
    end
  end

  // Request capture and result flags.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= request;
    end
    if (cmd.execute) begin
      pop_ok <= rd_en;
      status <= status_next;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.execute) begin
      head  <= head_next;
      count <= count_next;
    end
  end

  assign result.popped_value = pop_ok ? rdata : 32'sd0;
  assign result.status       = status;
  assign result.fill_level   = 5'(count);

endmodule

### hw/rtl/bounded_deque_top.sv
// Bounded double-ended queue of signed 32-bit words in a circular buffer.
// A request is accepted in IDLE, the memory access runs in EXEC, and the result
// strobe is high in REPLY, the state that follows EXEC.
// A new request is taken only once the sequencer is back in IDLE after the result,
// so requests do not overlap; busy is high until the strobe ends.
// Reset empties the queue; the result is shown for one cycle and cannot stall.
module bounded_deque_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  bdq_pkg::req_word_t request,
  output logic               done,
  output bdq_pkg::res_word_t result
);
  import bdq_pkg::*;

  bdq_cmd_t cmd;

  bdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  bdq_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .result  (result)
  );

endmodule

### dv/bounded_deque_top_tb.sv
`timescale 1ns / 1ps

module bounded_deque_top_tb;

  import bdq_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int MAX_GAP     = 60;
  localparam int DRAIN_WAIT  = 8;

  // Mirror of the queue contents and the results still to be seen.
  class deque_tracker;
    logic signed [31:0] slots [DEPTH];
    int unsigned        front_slot;
    int unsigned        held;
    res_word_t          due_results [$];
    int                 errors;

    function new();
      front_slot = 0;
      held       = 0;
      errors     = 0;
    endfunction

    // Apply one accepted word to the mirror and queue the result it causes.
    function void note_request(req_word_t w);
      res_word_t   r;
      int unsigned idx;
      r        = '0;
      r.status = ST_DONE;
      case (w.action)
        ACT_PUSH_BACK: begin
          if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            idx        = (front_slot + held) % DEPTH;
            slots[idx] = w.push_value;
            held++;
          end
        end
        ACT_PUSH_FRONT: begin
          if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            front_slot        = (front_slot + DEPTH - 1) % DEPTH;
            slots[front_slot] = w.push_value;
            held++;
          end
        end
        ACT_POP_FRONT: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.popped_value = slots[front_slot];
            front_slot     = (front_slot + 1) % DEPTH;
            held--;
          end
        end
        default: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            idx            = (front_slot + held - 1) % DEPTH;
            r.popped_value = slots[idx];
            held--;
          end
        end
      endcase
      r.fill_level = 5'(held);
      due_results.push_back(r);
    endfunction

    // Compare a result word with the oldest one still due.
    function void check_result(res_word_t got);
      res_word_t want;
      if (due_results.size() == 0) begin
        $error("result word with none due: popped_value %0d status %0d fill_level %0d",
               got.popped_value, got.status, got.fill_level);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.popped_value !== want.popped_value) begin
        $error("popped_value: expected %0d, actual %0d", want.popped_value, got.popped_value);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.fill_level !== want.fill_level) begin
        $error("fill_level: expected %0d, actual %0d", want.fill_level, got.fill_level);
        errors++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  req_word_t request;
  logic      done;
  res_word_t result;

  deque_tracker tracker = new();
  int           stall_cycles;

  bounded_deque_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Every result word is checked on the edge that ends its strobe cycle.
  always @(posedge clk) begin
    if (!rst && done) begin
      tracker.check_result(result);
    end
  end

  // Give up if nothing moves in either direction for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Extremes and small values turn up often; the rest is any 32-bit word.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return -32'sd1;
      3:       return 32'sd0;
      4, 5:    return 32'($urandom_range(255));
      default: return 32'($urandom);
    endcase
  endfunction

  // Lean towards pushes or pops so the queue swings between full and empty.
  function automatic logic [1:0] pick_action(int unsigned lean);
    int unsigned push_pct;
    push_pct = (lean == 0) ? 72 : (lean == 1) ? 28 : 50;
    if ($urandom_range(99) < push_pct) begin
      return $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
    end
    return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
  endfunction

  // Offer one word after a random gap and hold it until the block takes it.
  task automatic send_word(input logic [1:0] act, input logic signed [31:0] value,
                           input int unsigned idle_pct);
    int unsigned gap;
    req_word_t   w;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.action     = act;
    w.push_value = value;
    request <= w;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    tracker.note_request(w);
  endtask

  // Random words in stretches that lean one way or the other.
  task automatic run_random(input int unsigned count, input int unsigned idle_pct);
    int unsigned lean;
    lean = 2;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) lean = $urandom_range(2);
      send_word(pick_action(lean), pick_value(), idle_pct);
    end
  endtask

  initial begin
    rst     <= 1'b1;
    start   <= 1'b0;
    request <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pops on an empty queue.
    send_word(ACT_POP_FRONT, 32'sd5, 0);
    send_word(ACT_POP_BACK, -32'sd5, 0);
    // Fill from both ends, with the extreme values among the first words.
    send_word(ACT_PUSH_BACK, 32'sh7fffffff, 0);
    send_word(ACT_PUSH_FRONT, 32'sh80000000, 0);
    send_word(ACT_PUSH_BACK, -32'sd1, 0);
    send_word(ACT_PUSH_FRONT, 32'sd0, 0);
    for (int k = 0; k < 12; k++) begin
      send_word(k[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK, 32'($urandom), 0);
    end
    // Pushes at either end of a full queue.
    send_word(ACT_PUSH_BACK, 32'sd1, 0);
    send_word(ACT_PUSH_FRONT, 32'sd2, 0);
    send_word(ACT_POP_FRONT, 32'sd0, 0);
    send_word(ACT_POP_BACK, 32'sd0, 0);

    // Random words with the sender idling in different amounts.
    run_random(240, 0);
    run_random(230, 82);
    run_random(230, 24);
    start <= 1'b0;

    while (tracker.pending() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### bounded_deque_top.f
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_ctrl.sv
hw/rtl/bdq_datapath.sv
hw/rtl/bounded_deque_top.sv
dv/bounded_deque_top_tb.sv
